// ===== sv/ffra_pkg.sv =====
package ffra_pkg;

    localparam int OFFSET_W = 28;
    localparam int SIZE_W   = 29;
    localparam int GAP_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] CHUNK_RESET = 29'd268435456;
    localparam logic [GAP_W-1:0]  GAP_RESET   = 16'd2048;
    localparam logic [SIZE_W-1:0] SIZE_MAX    = {SIZE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_GAP  = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_NOT_FOUND   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_NEXT,
        S_CAND,
        S_FSCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size;
    } entry_t;

endpackage

// ===== sv/ffra_ram.sv =====
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/first_fit_region_allocator.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_op, s_req_size, s_req_offset
// m_        out        m_valid / m_ready  m_status, m_alloc_offset, m_total_used
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One request is handled at a time; the region table is one RAM read one entry per cycle.
// An allocation into a full table, or a free with no active regions, goes straight to the
// reply state without reading the table. Reset clears the region count and the running
// total; table contents are never read before they are written. A stalled result holds
// the block in its reply state.
module first_fit_region_allocator #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [ffra_pkg::SIZE_W-1:0]          s_req_size,
    input  logic [ffra_pkg::OFFSET_W-1:0]        s_req_offset,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [ffra_pkg::OFFSET_W-1:0]        m_alloc_offset,
    output logic [ffra_pkg::SIZE_W-1:0]          m_total_used,
    input  logic                                 cfg_we,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffra_pkg::SIZE_W-1:0]          cfg_wdata
);

    localparam int IDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int ENTRY_W = $bits(ffra_pkg::entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    ffra_pkg::state_t  state_reg, state_next;
    ffra_pkg::status_t res_reg, res_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  cidx_reg, cidx_next;
    logic [ffra_pkg::SIZE_W-1:0]   used_reg, used_next;
    logic [ffra_pkg::SIZE_W-1:0]   chunk_reg;
    logic [ffra_pkg::GAP_W-1:0]    gap_reg;
    logic                          m_valid_reg, m_valid_next;
    ffra_pkg::status_t             m_status_reg, m_status_next;
    logic [ffra_pkg::OFFSET_W-1:0] m_offset_reg, m_offset_next;
    logic [ffra_pkg::SIZE_W-1:0]   m_total_reg, m_total_next;

    logic                          op_reg, op_next;
    logic [ffra_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [ffra_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [29:0]                   cand_reg, cand_next;
    logic [29:0]                   end_reg, end_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [IDX_W-1:0]     ram_raddr;
    ffra_pkg::entry_t     ram_wentry;
    logic [ENTRY_W-1:0]   ram_rdata;
    ffra_pkg::entry_t     rd_entry;

    assign rd_entry = ffra_pkg::entry_t'(ram_rdata);

    ffra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ram_wentry)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        logic [30:0] end_c;
        logic        range_ok;
        logic [29:0] off30;
        logic [29:0] a30;
        logic [29:0] aend30;
        logic        hit;
        logic        last;
        logic        match;
        logic [29:0] sum_c;

        state_next    = state_reg;
        res_next      = res_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        cidx_next     = cidx_reg;
        used_next     = used_reg;
        op_next       = op_reg;
        size_next     = size_reg;
        off_next      = off_reg;
        cand_next     = cand_reg;
        end_next      = end_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_offset_next = m_offset_reg;
        m_total_next  = m_total_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IDX_W-1:0];
        ram_wentry    = '{offset: cand_reg[ffra_pkg::OFFSET_W-1:0], size: size_reg};
        ram_raddr     = scan_reg[IDX_W-1:0];

        end_c    = {1'b0, cand_reg} + {2'b00, size_reg};
        range_ok = (cand_reg[29:28] == 2'b00) && (end_c < {2'b00, chunk_reg});
        off30    = {2'b00, cand_reg[ffra_pkg::OFFSET_W-1:0]};
        a30      = {2'b00, rd_entry.offset};
        aend30   = a30 + {1'b0, rd_entry.size};
        hit      = (off30 >= a30 && off30 <= aend30) ||
                   (end_reg >= a30 && end_reg <= aend30) ||
                   (off30 <= a30 && end_reg >= aend30);
        last     = ((scan_reg + CNT_W'(1)) == count_reg);
        match    = (rd_entry.offset == off_reg) && (rd_entry.size == size_reg);
        sum_c    = {1'b0, used_reg} + {1'b0, size_reg};

        case (state_reg)
            ffra_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_op;
                    size_next = s_req_size;
                    off_next  = s_req_offset;
                    cand_next = '0;
                    cidx_next = '0;
                    scan_next = '0;
                    ram_raddr = '0;
                    if (s_op == ffra_pkg::OP_ALLOC) begin
                        if (count_reg >= CNT_MAX) begin
                            res_next   = ffra_pkg::ST_TABLE_FULL;
                            state_next = ffra_pkg::S_RESP;
                        end else begin
                            state_next = ffra_pkg::S_CHECK;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_next   = ffra_pkg::ST_NOT_FOUND;
                            state_next = ffra_pkg::S_RESP;
                        end else begin
                            state_next = ffra_pkg::S_FSCAN;
                        end
                    end
                end
            end
            ffra_pkg::S_CHECK: begin
                end_next = end_c[29:0];
                if (!range_ok) begin
                    state_next = ffra_pkg::S_NEXT;
                end else if (count_reg == '0) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    used_next  = sum_c[29] ? ffra_pkg::SIZE_MAX : sum_c[ffra_pkg::SIZE_W-1:0];
                    res_next   = ffra_pkg::ST_DONE;
                    state_next = ffra_pkg::S_RESP;
                end else begin
                    scan_next  = '0;
                    ram_raddr  = '0;
                    state_next = ffra_pkg::S_SCAN;
                end
            end
            ffra_pkg::S_SCAN: begin
                if (hit) begin
                    state_next = ffra_pkg::S_NEXT;
                end else if (last) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    used_next  = sum_c[29] ? ffra_pkg::SIZE_MAX : sum_c[ffra_pkg::SIZE_W-1:0];
                    res_next   = ffra_pkg::ST_DONE;
                    state_next = ffra_pkg::S_RESP;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    ram_raddr = scan_next[IDX_W-1:0];
                end
            end
            ffra_pkg::S_NEXT: begin
                if (cidx_reg == count_reg) begin
                    res_next   = ffra_pkg::ST_NO_SPACE;
                    state_next = ffra_pkg::S_RESP;
                end else begin
                    ram_raddr  = cidx_reg[IDX_W-1:0];
                    state_next = ffra_pkg::S_CAND;
                end
            end
            ffra_pkg::S_CAND: begin
                cand_next  = aend30 + {14'd0, gap_reg};
                cidx_next  = cidx_reg + CNT_W'(1);
                state_next = ffra_pkg::S_CHECK;
            end
            ffra_pkg::S_FSCAN: begin
                if (match && last) begin
                    count_next = count_reg - CNT_W'(1);
                    used_next  = (used_reg >= size_reg) ? used_reg - size_reg : '0;
                    res_next   = ffra_pkg::ST_DONE;
                    state_next = ffra_pkg::S_RESP;
                end else if (last) begin
                    res_next   = ffra_pkg::ST_NOT_FOUND;
                    state_next = ffra_pkg::S_RESP;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    ram_raddr = scan_next[IDX_W-1:0];
                    if (match) begin
                        state_next = ffra_pkg::S_SHIFT;
                    end
                end
            end
            ffra_pkg::S_SHIFT: begin
                ram_we     = 1'b1;
                scan_next  = scan_reg - CNT_W'(1);
                ram_waddr  = scan_next[IDX_W-1:0];
                ram_wentry = rd_entry;
                if (last) begin
                    scan_next  = scan_reg;
                    count_next = count_reg - CNT_W'(1);
                    used_next  = (used_reg >= size_reg) ? used_reg - size_reg : '0;
                    res_next   = ffra_pkg::ST_DONE;
                    state_next = ffra_pkg::S_RESP;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                    ram_raddr = scan_next[IDX_W-1:0];
                end
            end
            ffra_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_reg;
                    m_total_next  = used_reg;
                    if (op_reg == ffra_pkg::OP_ALLOC && res_reg == ffra_pkg::ST_DONE) begin
                        m_offset_next = cand_reg[ffra_pkg::OFFSET_W-1:0];
                    end else begin
                        m_offset_next = '0;
                    end
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffra_pkg::S_IDLE;
            res_reg     <= ffra_pkg::ST_DONE;
            count_reg   <= '0;
            scan_reg    <= '0;
            cidx_reg    <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            chunk_reg   <= ffra_pkg::CHUNK_RESET;
            gap_reg     <= ffra_pkg::GAP_RESET;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            cidx_reg    <= cidx_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    ffra_pkg::CFG_CHUNK_SIZE: chunk_reg <= cfg_wdata;
                    ffra_pkg::CFG_GUARD_GAP:  gap_reg   <= cfg_wdata[ffra_pkg::GAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        size_reg     <= size_next;
        off_reg      <= off_next;
        cand_reg     <= cand_next;
        end_reg      <= end_next;
        m_status_reg <= m_status_next;
        m_offset_reg <= m_offset_next;
        m_total_reg  <= m_total_next;
    end

    assign s_ready        = (state_reg == ffra_pkg::S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_offset = m_offset_reg;
    assign m_total_used   = m_total_reg;

`ifndef SYNTHESIS
    // The table never holds more regions than it has room for.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("region count exceeds table depth");

    // With no active regions the running total must be zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (used_reg == '0))
        else $error("running total nonzero with empty table");

    // A result only appears on leaving the reply state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ffra_pkg::S_RESP))
        else $error("result raised outside reply state");

    // A request transfer always starts the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ffra_pkg::S_IDLE))
        else $error("accepted request left sequencer idle");
`endif

endmodule
